>>> sv/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg: shared definitions of the HTML entity UTF-8 decoder
// Command and status bundles between controller and datapath, selector
// codes, the named entity table and the UTF-8 helper functions.
// ----------------------------------------------------------------------------
package hed_pkg;

	// Insert modes; any other value behaves as no insertion.
	localparam logic [1:0] MODE_ZWSP = 2'd1;
	localparam logic [1:0] MODE_WJ   = 2'd2;

	// Outcome of offering one byte to a pending reference.
	localparam logic [1:0] CLS_HOLD = 2'd0;
	localparam logic [1:0] CLS_DONE = 2'd1;
	localparam logic [1:0] CLS_FAIL = 2'd2;

	// Source of the byte being put (also the controller's job phase).
	localparam logic [1:0] JS_CP   = 2'd0;
	localparam logic [1:0] JS_AMP  = 2'd1;
	localparam logic [1:0] JS_HELD = 2'd2;
	localparam logic [1:0] JS_C    = 2'd3;

	// Source of an emitted byte.
	localparam logic [1:0] ES_TAIL = 2'd0;
	localparam logic [1:0] ES_INS  = 2'd1;
	localparam logic [1:0] ES_JOB  = 2'd2;

	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam int          NAME_COUNT = 46;

	localparam logic [47:0] NAME_STR [NAME_COUNT] = '{
		"amp", "nbsp", "ensp", "emsp", "thinsp", "zwnj", "zwj", "lrm",
		"rlm", "ndash", "lsquo", "rsquo", "sbquo", "ldquo", "rdquo", "bdquo",
		"dagger", "Dagger", "bull", "hellip", "permil", "prime", "Prime", "lsaquo",
		"rsaquo", "oline", "frasl", "lt", "gt", "middot", "mldr", "cacute",
		"quot", "amacr", "caron", "emacr", "mdash", "copy", "times", "darr",
		"imacr", "iacute", "igrave", "agrave", "ge", "le"
	};

	localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
		3'd3, 3'd4, 3'd4, 3'd4, 3'd6, 3'd4, 3'd3, 3'd3,
		3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd6, 3'd6, 3'd4, 3'd6, 3'd6, 3'd5, 3'd5, 3'd6,
		3'd6, 3'd5, 3'd5, 3'd2, 3'd2, 3'd6, 3'd4, 3'd6,
		3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4,
		3'd5, 3'd6, 3'd6, 3'd6, 3'd2, 3'd2
	};

	localparam logic [20:0] NAME_CP [NAME_COUNT] = '{
		21'h26, 21'hA0, 21'h2002, 21'h2003, 21'h2009, 21'h200C, 21'h200D, 21'h200E,
		21'h200F, 21'h2013, 21'h2018, 21'h2019, 21'h201A, 21'h201C, 21'h201D, 21'h201E,
		21'h2020, 21'h2021, 21'h2022, 21'h2026, 21'h2030, 21'h2032, 21'h2033, 21'h2039,
		21'h203A, 21'h203E, 21'h2044, 21'h3C, 21'h3E, 21'hB7, 21'h2026, 21'h107,
		21'h22, 21'h101, 21'h2C7, 21'h113, 21'h2014, 21'hA9, 21'hD7, 21'h2193,
		21'h12B, 21'hED, 21'hEC, 21'hE0, 21'h2265, 21'h2264
	};

	typedef struct packed {
		logic       capture;
		logic       pre_clr;
		logic       cls_upd;
		logic       last_fail;
		logic [1:0] jsel;
		logic [2:0] idx;
		logic       fresh;
		logic       ins_end;
		logic       put_upd;
		logic       tail_clr;
		logic       tail_store;
		logic       emit;
		logic [1:0] esel;
		logic [1:0] sub;
		logic       flush;
		logic       finish;
	} hed_cmd_t;

	typedef struct packed {
		logic       wfill_nz;
		logic [1:0] cls;
		logic [2:0] ncp;
		logic [3:0] k;
		logic [2:0] tfill;
		logic       need_ins;
		logic       job_amp;
		logic       mode2;
		logic       append;
		logic       fin_store;
		logic       can_emit;
		logic       last;
	} hed_sts_t;

	// Character number of name i at position p, zero past its end.
	function automatic logic [7:0] name_chr(input int i, input int p);
		logic [47:0] s;
		int          l;
		s = NAME_STR[i];
		l = int'(NAME_LEN[i]);
		if (p >= l) return 8'h00;
		return s[(l - 1 - p) * 8 +: 8];
	endfunction

	// Byte count announced by a UTF-8 lead byte, zero for anything else.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		if (b[7] == 1'b0) return 3'd1;
		if (b[7:5] == 3'b110) return 3'd2;
		if (b[7:4] == 4'b1110) return 3'd3;
		if (b[7:3] == 5'b11110) return 3'd4;
		return 3'd0;
	endfunction

	function automatic logic is_cjk(input logic [20:0] c);
		return (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
			(c >= 21'h20000 && c <= 21'h2A6DF) || (c >= 21'h2E80 && c <= 21'h2EFF) ||
			(c >= 21'hF900 && c <= 21'hFAFF) || (c >= 21'h3040 && c <= 21'h30FF) ||
			(c >= 21'h31F0 && c <= 21'h31FF) || (c >= 21'h1100 && c <= 21'h11FF) ||
			(c >= 21'hAC00 && c <= 21'hD7A3);
	endfunction

endpackage

>>> sv/hed_ctrl.sv
// ----------------------------------------------------------------------------
// hed_ctrl: sequencing controller of the HTML entity UTF-8 decoder
// Steps each accepted byte through classification, the put jobs it causes
// and the end-of-string flush, one output byte per cycle at most.
// ----------------------------------------------------------------------------
module hed_ctrl import hed_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output hed_cmd_t cmd,
	input  hed_sts_t sts
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PRE   = 4'd1;
	localparam logic [3:0] S_CLS   = 4'd2;
	localparam logic [3:0] S_NEXT  = 4'd3;
	localparam logic [3:0] S_JINS  = 4'd4;
	localparam logic [3:0] S_JPUT  = 4'd5;
	localparam logic [3:0] S_JREL  = 4'd6;
	localparam logic [3:0] S_JFIN  = 4'd7;
	localparam logic [3:0] S_LAST  = 4'd8;
	localparam logic [3:0] S_FLUSH = 4'd9;
	localparam logic [3:0] S_END   = 4'd10;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [3:0] idx_q, idx_d;
	logic [2:0] sub_q, sub_d;
	logic       ret_q, ret_d;
	logic       job_done;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		idx_d    = idx_q;
		sub_d    = sub_q;
		ret_d    = ret_q;
		job_done = 1'b0;
		s_tready = 1'b0;
		cmd       = '0;
		cmd.jsel  = phase_q;
		cmd.idx   = idx_q[2:0];
		cmd.fresh = (phase_q == JS_HELD) || (phase_q == JS_C);
		cmd.sub   = sub_q[1:0];
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_PRE;
				end
			end
			S_PRE: begin
				if (sts.mode2) begin
					state_d = S_CLS;
				end else begin
					cmd.pre_clr = 1'b1;
					if (sub_q < sts.tfill) begin
						if (sts.can_emit) begin
							cmd.emit = 1'b1;
							cmd.esel = ES_TAIL;
							sub_d    = sub_q + 3'd1;
						end
					end else begin
						cmd.tail_clr = 1'b1;
						sub_d        = '0;
						state_d      = S_CLS;
					end
				end
			end
			S_CLS: begin
				ret_d = 1'b0;
				if (!sts.wfill_nz) begin
					phase_d = JS_C;
					state_d = S_JINS;
				end else begin
					cmd.cls_upd = 1'b1;
					case (sts.cls)
						CLS_HOLD: state_d = S_LAST;
						CLS_DONE: begin
							phase_d = JS_CP;
							idx_d   = '0;
							state_d = S_NEXT;
						end
						default: begin
							phase_d = JS_AMP;
							state_d = S_NEXT;
						end
					endcase
				end
			end
			S_NEXT: begin
				case (phase_q)
					JS_CP: state_d = (idx_q < {1'b0, sts.ncp}) ? S_JINS : S_LAST;
					JS_HELD: begin
						if (idx_q < sts.k) begin
							state_d = S_JINS;
						end else if (ret_q) begin
							sub_d   = '0;
							state_d = S_FLUSH;
						end else begin
							phase_d = JS_C;
							state_d = S_JINS;
						end
					end
					default: state_d = S_JINS;
				endcase
			end
			S_JINS: begin
				if (sts.need_ins) begin
					if (sts.can_emit) begin
						cmd.emit = 1'b1;
						cmd.esel = ES_INS;
						if (sub_q == 3'd2) begin
							cmd.ins_end = 1'b1;
							sub_d       = '0;
							if (sts.job_amp) job_done = 1'b1;
							else state_d = S_JPUT;
						end else begin
							sub_d = sub_q + 3'd1;
						end
					end
				end else begin
					cmd.ins_end = cmd.fresh;
					if (cmd.fresh && sts.job_amp) job_done = 1'b1;
					else state_d = S_JPUT;
				end
			end
			S_JPUT: begin
				if (!sts.mode2) begin
					if (sts.can_emit) begin
						cmd.emit = 1'b1;
						cmd.esel = ES_JOB;
						job_done = 1'b1;
					end
				end else begin
					cmd.put_upd = 1'b1;
					if (sts.append) begin
						job_done = 1'b1;
					end else begin
						sub_d   = '0;
						state_d = S_JREL;
					end
				end
			end
			S_JREL: begin
				if (sub_q < sts.tfill) begin
					if (sts.can_emit) begin
						cmd.emit = 1'b1;
						cmd.esel = ES_TAIL;
						sub_d    = sub_q + 3'd1;
					end
				end else begin
					cmd.tail_clr = 1'b1;
					sub_d        = '0;
					state_d      = S_JFIN;
				end
			end
			S_JFIN: begin
				if (sts.fin_store) begin
					cmd.tail_store = 1'b1;
					job_done       = 1'b1;
				end else if (sts.can_emit) begin
					cmd.emit = 1'b1;
					cmd.esel = ES_JOB;
					job_done = 1'b1;
				end
			end
			S_LAST: begin
				if (!sts.last) begin
					state_d = S_END;
				end else if (sts.wfill_nz) begin
					cmd.last_fail = 1'b1;
					phase_d       = JS_AMP;
					ret_d         = 1'b1;
					state_d       = S_NEXT;
				end else begin
					sub_d   = '0;
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (sub_q < sts.tfill) begin
					if (sts.can_emit) begin
						cmd.emit = 1'b1;
						cmd.esel = ES_TAIL;
						sub_d    = sub_q + 3'd1;
					end
				end else begin
					cmd.tail_clr = 1'b1;
					cmd.flush    = 1'b1;
					sub_d        = '0;
					state_d      = S_END;
				end
			end
			S_END: begin
				if (sts.can_emit) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// Move on to the next put job once the current one has finished.
		if (job_done) begin
			case (phase_q)
				JS_CP: begin
					idx_d   = idx_q + 4'd1;
					state_d = S_NEXT;
				end
				JS_AMP: begin
					phase_d = JS_HELD;
					idx_d   = '0;
					state_d = S_NEXT;
				end
				JS_HELD: begin
					idx_d   = idx_q + 4'd1;
					state_d = S_NEXT;
				end
				default: state_d = S_LAST;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= JS_C;
			idx_q   <= '0;
			sub_q   <= '0;
			ret_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
			sub_q   <= sub_d;
			ret_q   <= ret_d;
		end
	end

endmodule

>>> sv/hed_datapath.sv
// ----------------------------------------------------------------------------
// hed_datapath: data storage and decode logic of the HTML entity decoder
// Holds the reference window, the withheld output character, the string
// flags and the output stage, and reports status to the controller.
// ----------------------------------------------------------------------------
module hed_datapath import hed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic [1:0] mode,
	input  hed_cmd_t   cmd,
	output hed_sts_t   sts,
	input  logic       m_tready,
	output logic       m_tvalid,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [7:0]            c_q;
	logic                  last_q;
	logic [7:0]            win_q [8];
	logic [3:0]            wfill_q;
	logic [3:0]            k_q;
	logic [NAME_COUNT-1:0] mask_q;
	logic [23:0]           num_q;
	logic [20:0]           cp_q;
	logic [7:0]            tail_q [4];
	logic [2:0]            tfill_q;
	logic                  prev_q;
	logic                  started_q;
	logic [7:0]            pend_q;
	logic                  pend_v_q;
	logic [7:0]            out_q;
	logic                  out_v_q;
	logic                  out_last_q;

	logic [3:0]            n;
	logic [2:0]            ncp;
	logic [7:0]            job_b;
	logic [2:0]            lead_b;
	logic [2:0]            tail_lead;
	logic [20:0]           tail_cp;
	logic                  tail_cjk;
	logic                  is_num, hex;
	logic [3:0]            d;
	logic                  dig_ok;
	logic [3:0]            dval;
	logic [23:0]           num_next;
	logic [NAME_COUNT-1:0] nm_next, nm_end;
	logic [20:0]           name_cp;
	logic [1:0]            cls;
	logic [20:0]           cls_cp;
	logic [7:0]            ebyte;
	logic                  out_free;

	function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [2:0] cnt,
		input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (cnt)
			3'd1: r = cp[7:0];
			3'd2: r = (i == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				case (i)
					3'd0: r = {4'b1110, cp[15:12]};
					3'd1: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (i)
					3'd0: r = {5'b11110, cp[20:18]};
					3'd1: r = {2'b10, cp[17:12]};
					3'd2: r = {2'b10, cp[11:6]};
					default: r = {2'b10, cp[5:0]};
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	assign n = wfill_q - 4'd1;

	always_comb begin
		if (cp_q == 21'd0) ncp = 3'd0;
		else if (cp_q < 21'h80) ncp = 3'd1;
		else if (cp_q < 21'h800) ncp = 3'd2;
		else if (cp_q < 21'h10000) ncp = 3'd3;
		else ncp = 3'd4;
	end

	always_comb begin
		case (cmd.jsel)
			JS_CP:   job_b = cp_byte(cp_q, ncp, cmd.idx);
			JS_AMP:  job_b = "&";
			JS_HELD: job_b = win_q[cmd.idx];
			default: job_b = c_q;
		endcase
	end

	assign lead_b    = lead_len(job_b);
	assign tail_lead = lead_len(tail_q[0]);

	// The withheld character counts as CJK only when it is complete.
	always_comb begin
		if (tail_lead == 3'd3) tail_cp = {5'd0, tail_q[0][3:0], tail_q[1][5:0], tail_q[2][5:0]};
		else tail_cp = {tail_q[0][2:0], tail_q[1][5:0], tail_q[2][5:0], tail_q[3][5:0]};
		tail_cjk = (tfill_q != 3'd0) && (tail_lead >= 3'd3) && (tail_lead == tfill_q) &&
			is_cjk(tail_cp);
	end

	// Numeric references: the value is accumulated as the digits arrive.
	always_comb begin
		is_num = (n != 4'd0) && (win_q[0] == "#");
		hex    = (n >= 4'd2) && (win_q[1] == "x");
		d      = n - (hex ? 4'd2 : 4'd1);
		dig_ok = 1'b0;
		dval   = 4'd0;
		if (c_q >= "0" && c_q <= "9") begin
			dig_ok = 1'b1;
			dval   = 4'(c_q - "0");
		end else if (hex && c_q >= "a" && c_q <= "f") begin
			dig_ok = 1'b1;
			dval   = 4'(c_q - "a" + 8'd10);
		end else if (hex && c_q >= "A" && c_q <= "F") begin
			dig_ok = 1'b1;
			dval   = 4'(c_q - "A" + 8'd10);
		end
		if (hex) num_next = {num_q[19:0], dval};
		else num_next = (num_q << 3) + (num_q << 1) + {20'd0, dval};
	end

	// Named references: one candidate bit per table entry narrows per byte.
	always_comb begin
		nm_next = '0;
		nm_end  = '0;
		name_cp = '0;
		for (int i = 0; i < NAME_COUNT; i++) begin
			for (int p = 0; p < 8; p++) begin
				if (n == 4'(p) && int'(NAME_LEN[i]) > p && name_chr(i, p) == c_q)
					nm_next[i] = mask_q[i];
			end
			nm_end[i] = mask_q[i] && ({1'b0, NAME_LEN[i]} == n);
			if (nm_end[i]) name_cp = name_cp | NAME_CP[i];
		end
	end

	always_comb begin
		cls    = CLS_FAIL;
		cls_cp = name_cp;
		if (n == 4'd0 && c_q == "#") begin
			cls = CLS_HOLD;
		end else if (is_num) begin
			cls_cp = num_q[20:0];
			if (n == 4'd1 && c_q == "x") cls = CLS_HOLD;
			else if (c_q == ";")
				cls = (d == 4'd0 || num_q > {3'd0, CP_MAX}) ? CLS_FAIL : CLS_DONE;
			else if (dig_ok && d < (hex ? 4'd6 : 4'd7)) cls = CLS_HOLD;
		end else if (c_q == ";") begin
			cls = (|nm_end) ? CLS_DONE : CLS_FAIL;
		end else begin
			cls = (|nm_next) ? CLS_HOLD : CLS_FAIL;
		end
	end

	always_comb begin
		case (cmd.esel)
			ES_TAIL: ebyte = tail_q[cmd.sub];
			ES_INS: begin
				case (cmd.sub)
					2'd0:    ebyte = 8'hE2;
					2'd1:    ebyte = (mode == MODE_ZWSP) ? 8'h80 : 8'h81;
					default: ebyte = (mode == MODE_ZWSP) ? 8'h8B : 8'hA0;
				endcase
			end
			default: ebyte = job_b;
		endcase
	end

	assign out_free = !out_v_q || m_tready;

	always_comb begin
		sts.wfill_nz  = (wfill_q != 4'd0);
		sts.cls       = cls;
		sts.ncp       = ncp;
		sts.k         = k_q;
		sts.tfill     = tfill_q;
		sts.need_ins  = cmd.fresh && started_q && (lead_b != 3'd0) &&
			((mode == MODE_ZWSP) || (mode == MODE_WJ && prev_q && tail_cjk));
		sts.job_amp   = (job_b == "&");
		sts.mode2     = (mode == MODE_WJ);
		sts.append    = (job_b[7:6] == 2'b10) && (tfill_q != 3'd0) && (tfill_q < tail_lead);
		sts.fin_store = (lead_b >= 3'd3);
		sts.can_emit  = !pend_v_q || out_free;
		sts.last      = last_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wfill_q    <= '0;
			tfill_q    <= '0;
			prev_q     <= 1'b0;
			started_q  <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.cls_upd) begin
				if (cls == CLS_HOLD) wfill_q <= wfill_q + 4'd1;
				else wfill_q <= '0;
			end
			if (cmd.last_fail) wfill_q <= '0;
			if (cmd.pre_clr) prev_q <= 1'b0;
			if (cmd.ins_end) begin
				started_q <= 1'b1;
				if (sts.need_ins && mode == MODE_WJ) prev_q <= 1'b0;
				if (job_b == "&") wfill_q <= 4'd1;
			end
			if (cmd.put_upd) begin
				if (lead_b != 3'd0) prev_q <= tail_cjk;
				else if (sts.append) tfill_q <= tfill_q + 3'd1;
				else if (job_b[7:6] != 2'b10) prev_q <= 1'b0;
			end
			if (cmd.tail_clr) tfill_q <= '0;
			if (cmd.tail_store) tfill_q <= 3'd1;
			if (cmd.flush) begin
				prev_q    <= 1'b0;
				started_q <= 1'b0;
				wfill_q   <= '0;
			end
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
				else if (out_v_q && m_tready) out_v_q <= 1'b0;
			end else if (cmd.finish && pend_v_q) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			c_q    <= in_byte;
			last_q <= in_last;
		end
		if (cmd.cls_upd) begin
			if (cls == CLS_HOLD) begin
				win_q[n[2:0]] <= c_q;
				mask_q        <= nm_next;
				if (is_num && dig_ok) num_q <= num_next;
			end else if (cls == CLS_DONE) begin
				cp_q <= cls_cp;
			end else begin
				k_q <= n;
			end
		end
		if (cmd.last_fail) k_q <= n;
		if (cmd.ins_end && job_b == "&") begin
			mask_q <= '1;
			num_q  <= '0;
		end
		if (cmd.put_upd && lead_b == 3'd0 && sts.append) tail_q[tfill_q[1:0]] <= job_b;
		if (cmd.tail_store) tail_q[0] <= job_b;
		if (cmd.emit) begin
			pend_q <= ebyte;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.finish && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign m_tlast  = out_last_q;

endmodule

>>> sv/html_entity_utf8_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_utf8_decoder: streaming HTML character reference decoder
// Decodes numeric and named references in UTF-8 text and can insert
// separators between characters.
// ----------------------------------------------------------------------------
// Usage. Text enters on the s_ channel one byte per transfer; s_tlast marks
// the final byte of a string and flushes any held reference and any
// withheld character. Decoded bytes leave on the m_ channel; m_tlast marks
// the last output byte caused by one input byte, and a byte that causes no
// output gives no transfer at all. insert_mode sits at byte address 0 of
// the APB port and must be written only while the block is idle; the block
// itself does not enforce this. Throughput: one input byte is worked on at
// a time. The controller steps the datapath through at most one output byte
// per cycle while the receiver keeps up.
// Output: every output byte waits in a holding stage until the next one is
// produced or the item ends, so that its last marker is known.
// Reset clears every flag, the pending reference and the output stage; the
// block then accepts at once. A stalled receiver stops the sequencer once
// both the holding stage and the output stage are full; s_tready stays low
// until the item is finished.
// ----------------------------------------------------------------------------
module html_entity_utf8_decoder import hed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // [7:0] out_byte
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Register index of insert_mode, taken from paddr[2].
	localparam logic REG_INSERT_MODE = 1'b0;

	logic [1:0] mode_q;
	hed_cmd_t   cmd;
	hed_sts_t   sts;

	// The register is written in the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
		end else if (psel && penable && pwrite && paddr[2] == REG_INSERT_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INSERT_MODE) ? {30'd0, mode_q} : 32'd0;

	// The controller walks each item through its jobs.
	hed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the text state and the output stage.
	hed_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.mode     (mode_q),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> sv/hed_checker.sv
// ----------------------------------------------------------------------------
// hed_checker: port-level checks of the HTML entity UTF-8 decoder
// Watches the top level's ports and is attached to it by a bind.
// ----------------------------------------------------------------------------
module hed_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// Nothing is offered on the output while reset stays asserted.
	a_reset_quiet: assert property (@(posedge clk) !arst_n && $past(!arst_n) |-> !m_tvalid)
		else $error("output valid during reset");

	// A stalled output transfer holds its byte and marker.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

	// One byte is worked on at a time: no back-to-back input transfers.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// A write to insert_mode reads back once the register has taken it.
	a_mode_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] && !$past(!arst_n)
		|=> (paddr[2] || prdata[1:0] == $past(pwdata[1:0])))
		else $error("insert_mode readback mismatch");

endmodule

bind html_entity_utf8_decoder hed_checker u_hed_checker (.*);
